// File: rtl/wes_pkg.sv
// Shared types, constants and a size-clamping helper for the wave-equation stencil step.
`timescale 1ns / 1ps
`default_nettype none

package wes_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_BITS   = 16;
  localparam int SIZE_BITS   = 11;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
  localparam int CFG_BITS    = 16;
  localparam int MIN_SIZE    = 3;

  localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = SIZE_BITS'(256);
  localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = SIZE_BITS'(256);
  localparam logic [GAIN_BITS-1:0] RESET_GAIN   = GAIN_BITS'(16384);

  typedef enum logic [1:0] {
    CFG_GRID_WIDTH   = 2'd0,
    CFG_GRID_HEIGHT  = 2'd1,
    CFG_COURANT_GAIN = 2'd2
  } wes_cfg_idx_t;

  typedef struct packed {
    logic [COL_BITS-1:0] x;
    logic                interior;
    logic                emit;
    logic                last_row;
    logic                last_col;
  } wes_pos_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] new_value;
    logic [SAMPLE_BITS-1:0] old_value;
    logic                   last_in_run;
    logic                   frame_end;
  } wes_result_t;

  function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v,
                                                      input int unsigned hi);
    logic [SIZE_BITS-1:0] r;
    if (v < SIZE_BITS'(MIN_SIZE)) begin
      r = SIZE_BITS'(MIN_SIZE);
    end else if (v > SIZE_BITS'(hi)) begin
      r = SIZE_BITS'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/wes_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
`timescale 1ns / 1ps
`default_nettype none

module wes_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/wes_raster.sv
// Raster position counters: column and row of each arriving cell.
`timescale 1ns / 1ps
`default_nettype none

module wes_raster
  import wes_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire logic                 frame_start,
  input  wire logic [SIZE_BITS-1:0] grid_width,
  input  wire logic [SIZE_BITS-1:0] grid_height,
  output wes_pos_t                  pos
);

  logic [COL_BITS-1:0]  col;
  logic [COL_BITS-1:0]  col_next;
  logic [ROW_BITS-1:0]  row;
  logic [ROW_BITS-1:0]  row_next;
  logic [SIZE_BITS-1:0] c;
  logic [SIZE_BITS-1:0] r;
  logic [SIZE_BITS-1:0] x1;
  logic [SIZE_BITS-1:0] y1;

  always_comb begin
    c = frame_start ? '0 : SIZE_BITS'(col);
    r = frame_start ? '0 : SIZE_BITS'(row);
    if (c >= grid_width) begin
      c = '0;
      r = r + 1'b1;
    end
    if (r >= grid_height) begin
      r = '0;
    end
    x1 = c + 1'b1;
    y1 = r + 1'b1;

    pos.x        = c[COL_BITS-1:0];
    pos.interior = (c != '0) && (x1 < grid_width) && (r >= SIZE_BITS'(2));
    pos.emit     = (r != '0);
    pos.last_row = (y1 == grid_height);
    pos.last_col = (x1 == grid_width);

    if (x1 >= grid_width) begin
      col_next = '0;
      row_next = (y1 >= grid_height) ? '0 : y1[ROW_BITS-1:0];
    end else begin
      col_next = x1[COL_BITS-1:0];
      row_next = r[ROW_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (advance) begin
      col <= col_next;
      row <= row_next;
    end
  end

  a_frame_start_pos : assert property (@(posedge clk) disable iff (rst)
    advance && frame_start |=> (col == COL_BITS'(1)) && (row == '0))
    else $error("frame start did not restart the raster position");

endmodule

`default_nettype wire

// File: rtl/wes_kernel.sv
// Five-point update of one interior cell with rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none

module wes_kernel
  import wes_pkg::*;
(
  input  wire logic signed [SAMPLE_BITS-1:0] center,
  input  wire logic signed [SAMPLE_BITS-1:0] left,
  input  wire logic signed [SAMPLE_BITS-1:0] right,
  input  wire logic signed [SAMPLE_BITS-1:0] up,
  input  wire logic signed [SAMPLE_BITS-1:0] down,
  input  wire logic signed [SAMPLE_BITS-1:0] prev_center,
  input  wire logic        [GAIN_BITS-1:0]   gain,
  output logic signed      [SAMPLE_BITS-1:0] new_value
);

  localparam int LAP_BITS  = SAMPLE_BITS + 3;
  localparam int PROD_BITS = LAP_BITS + GAIN_BITS + 1;
  localparam int TERM_BITS = PROD_BITS - 16;
  localparam int SUM_BITS  = TERM_BITS + 2;

  localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(32768);
  localparam logic signed [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [LAP_BITS-1:0]  lap;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [PROD_BITS-1:0] rounded;
  logic signed [TERM_BITS-1:0] term;
  logic signed [SUM_BITS-1:0]  sum;

  always_comb begin
    lap = LAP_BITS'(left) + LAP_BITS'(right) + LAP_BITS'(up) + LAP_BITS'(down)
        - (LAP_BITS'(center) <<< 2);
    prod    = $signed({1'b0, gain}) * lap;
    rounded = prod + ROUND_HALF;
    term    = rounded[PROD_BITS-1:16];
    sum     = (SUM_BITS'(center) <<< 1) - SUM_BITS'(prev_center) + SUM_BITS'(term);
    if (sum > SUM_BITS'(SAT_HI)) begin
      new_value = SAT_HI;
    end else if (sum < SUM_BITS'(SAT_LO)) begin
      new_value = SAT_LO;
    end else begin
      new_value = sum[SAMPLE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/wes_result_buf.sv
// Two-entry result register that presents one or two results per cell.
`timescale 1ns / 1ps
`default_nettype none

module wes_result_buf
  import wes_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire logic        two,
  input  wire wes_result_t res0,
  input  wire wes_result_t res1,
  output logic             free,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output wes_result_t      head
);

  logic        ov;
  logic        pend;
  wes_result_t r0;
  wes_result_t r1;

  assign free     = !ov || (m_tready && !pend);
  assign m_tvalid = ov;
  assign head     = r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov   <= 1'b0;
      pend <= 1'b0;
    end else if (load) begin
      ov   <= 1'b1;
      pend <= two;
    end else if (ov && m_tready) begin
      if (pend) begin
        pend <= 1'b0;
      end else begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      r0 <= res0;
      r1 <= res1;
    end else if (ov && m_tready && pend) begin
      r0 <= r1;
    end
  end

  a_pend_needs_valid : assert property (@(posedge clk) disable iff (rst)
    pend |-> ov)
    else $error("second result pending without a valid head");

  a_end_is_last : assert property (@(posedge clk) disable iff (rst)
    ov && r0.frame_end |-> r0.last_in_run)
    else $error("frame end on a result that is not last of its cell");

endmodule

`default_nettype wire

// File: rtl/wave_equation_stencil_step.sv
// Top level: one time step of the 2D wave equation over a raster cell stream.
// The result for a cell of row y-1 follows the transfer of the cell below it through the
// input register, then the result register, and is presented on m_tvalid from there.
// Throughput: one cell per cycle while the result port is free; a cell of the last row
// yields two results, the row above and the cell itself, on the single result port.
// Reset: position counters clear and the configuration and valid registers take their
// defaults; line buffers keep their contents and are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module wave_equation_stencil_step
  import wes_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // s_tdata: cur_value [15:0], prev_value [31:16]
  input  wire logic [31:0]          s_tdata,
  // s_tuser: frame_start
  input  wire logic                 s_tuser,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // m_tdata: new_value [15:0], old_value [31:16]
  output logic      [31:0]          m_tdata,
  // m_tuser: frame_end
  output logic                      m_tuser,
  output logic                      m_tlast,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [CFG_BITS-1:0]  cfg_data
);

  logic [SIZE_BITS-1:0]   grid_width;
  logic [SIZE_BITS-1:0]   grid_height;
  logic [GAIN_BITS-1:0]   courant_gain;

  wes_pos_t               pos;
  logic                   accept;
  logic                   s1_valid;
  logic                   s1_adv;
  wes_pos_t               s1_pos;
  logic [SAMPLE_BITS-1:0] s1_cur;
  logic [SAMPLE_BITS-1:0] left;
  logic [SAMPLE_BITS-1:0] a_center;
  logic [SAMPLE_BITS-1:0] a_right;
  logic [SAMPLE_BITS-1:0] b_up;
  logic [SAMPLE_BITS-1:0] p_center;
  logic [SAMPLE_BITS-1:0] kernel_value;
  logic                   out_free;
  wes_result_t            res0;
  wes_result_t            res1;
  wes_result_t            head;

  // configuration registers, sizes held clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= RESET_WIDTH;
      grid_height  <= RESET_HEIGHT;
      courant_gain <= RESET_GAIN;
    end else if (cfg_we) begin
      unique case (wes_cfg_idx_t'(cfg_index))
        CFG_GRID_WIDTH:   grid_width   <= clamp_size(cfg_data[SIZE_BITS-1:0], MAX_WIDTH);
        CFG_GRID_HEIGHT:  grid_height  <= clamp_size(cfg_data[SIZE_BITS-1:0], MAX_HEIGHT);
        CFG_COURANT_GAIN: courant_gain <= cfg_data[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv   = s1_valid && (!s1_pos.emit || out_free);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  wes_raster u_raster (
    .clk         (clk),
    .rst         (rst),
    .advance     (accept),
    .frame_start (s_tuser),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .pos         (pos)
  );

  // row above, current field: one copy read at x, one at x+1
  wes_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_above_center (
    .clk   (clk),
    .we    (accept),
    .waddr (pos.x),
    .wdata (s_tdata[SAMPLE_BITS-1:0]),
    .re    (accept),
    .raddr (pos.x),
    .rdata (a_center)
  );

  wes_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_above_right (
    .clk   (clk),
    .we    (accept),
    .waddr (pos.x),
    .wdata (s_tdata[SAMPLE_BITS-1:0]),
    .re    (accept),
    .raddr (pos.x + 1'b1),
    .rdata (a_right)
  );

  // two rows above, current field: takes the displaced row-above value
  wes_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_two_above (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_pos.x),
    .wdata (a_center),
    .re    (accept),
    .raddr (pos.x),
    .rdata (b_up)
  );

  wes_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_above_prev (
    .clk   (clk),
    .we    (accept),
    .waddr (pos.x),
    .wdata (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .re    (accept),
    .raddr (pos.x),
    .rdata (p_center)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos  <= pos;
      s1_cur  <= s_tdata[SAMPLE_BITS-1:0];
    end
    // left neighbour is the row-above value of the previous cell in the row
    if (s1_adv) begin
      left <= a_center;
    end
  end

  wes_kernel u_kernel (
    .center      (a_center),
    .left        (left),
    .right       (a_right),
    .up          (b_up),
    .down        (s1_cur),
    .prev_center (p_center),
    .gain        (courant_gain),
    .new_value   (kernel_value)
  );

  always_comb begin
    res0.new_value   = s1_pos.interior ? kernel_value : a_center;
    res0.old_value   = a_center;
    res0.last_in_run = !s1_pos.last_row;
    res0.frame_end   = 1'b0;
    res1.new_value   = s1_cur;
    res1.old_value   = s1_cur;
    res1.last_in_run = 1'b1;
    res1.frame_end   = s1_pos.last_col;
  end

  wes_result_buf u_result_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (s1_adv && s1_pos.emit),
    .two      (s1_pos.last_row),
    .res0     (res0),
    .res1     (res1),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata = {head.old_value, head.new_value};
  assign m_tlast = head.last_in_run;
  assign m_tuser = head.frame_end;

  a_s1_hold : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("input register dropped a stalled cell");

endmodule

`default_nettype wire
